@@ rtl/cdbm_pkg.sv @@
`timescale 1ns / 1ps

package cdbm_pkg;

    // sizes
    localparam int MAX_CLOCKS  = 8;
    localparam int VALUE_WIDTH = 17;
    localparam int DIM         = MAX_CLOCKS + 1;
    localparam int CELLS       = DIM * DIM;
    localparam int IDX_W       = $clog2(DIM);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CONST_W     = 15;
    localparam int ACT_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // one matrix entry
    typedef struct packed {
        logic                          inf;
        logic                          strict;
        logic signed [VALUE_WIDTH-1:0] val;
    } t_bound;

    localparam t_bound BOUND_ZERO  = '{inf: 1'b0, strict: 1'b0, val: '0};
    localparam t_bound BOUND_INF   = '{inf: 1'b1, strict: 1'b0, val: '0};
    localparam t_bound BOUND_EMPTY = '{inf: 1'b0, strict: 1'b1, val: '1};

    // command and result words
    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         clock_index;
        logic [2:0]         relation;
        logic [CONST_W-1:0] bound_constant;
    } t_cmd;

    typedef struct packed {
        logic               zone_empty;
        logic [CONST_W-1:0] lower_end;
        logic               lower_open;
        logic [CONST_W-1:0] upper_end;
        logic               upper_open;
    } t_result;

    // opcodes, relations, register indexes
    localparam logic [1:0] OP_DELAY     = 2'd0;
    localparam logic [1:0] OP_RESET     = 2'd1;
    localparam logic [1:0] OP_CONSTRAIN = 2'd2;
    localparam logic [1:0] OP_QUERY     = 2'd3;

    localparam logic [2:0] REL_LESS     = 3'd0;
    localparam logic [2:0] REL_EQUAL    = 3'd2;
    localparam logic [2:0] REL_GREATER  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXC   = 1'b1;

    localparam logic [ACT_W-1:0]   ACTIVE_RESET = 4'd8;
    localparam logic [CONST_W-1:0] MAXC_RESET   = 15'd255;

    // what the head of the chain does to the passing entry
    typedef enum logic [2:0] {
        M_PASS  = 3'd0,
        M_DELAY = 3'd1,
        M_RESET = 3'd2,
        M_APPLY = 3'd3,
        M_CLOSE = 3'd4,
        M_NORM  = 3'd5
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               in_rng;
        logic               col0_row;
        logic               row_idx;
        logic               col_idx;
        logic               at_xy;
        logic               at00;
        logic               diag;
        logic               wr_empty;
        logic               do_close;
        t_bound             bnd;
        t_bound             rn_j;
        t_bound             cn_i;
        t_bound             mik;
        t_bound             mkj;
        logic [CONST_W-1:0] maxc;
    } t_head_ctl;

    // saturating bound sum
    function automatic t_bound bound_add(input t_bound a, input t_bound b);
        logic signed [VALUE_WIDTH:0] s;
        t_bound r;
        s = signed'({a.val[VALUE_WIDTH-1], a.val}) + signed'({b.val[VALUE_WIDTH-1], b.val});
        r.inf    = 1'b0;
        r.strict = a.strict | b.strict;
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            r.val = s[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                   : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else begin
            r.val = s[VALUE_WIDTH-1:0];
        end
        if (a.inf || b.inf) begin
            r = BOUND_INF;
        end
        return r;
    endfunction

    // strict order on bounds
    function automatic logic bound_lt(input t_bound a, input t_bound b);
        logic r;
        if (a.inf) begin
            r = 1'b0;
        end else if (b.inf) begin
            r = 1'b1;
        end else if (a.val != b.val) begin
            r = (a.val < b.val);
        end else begin
            r = a.strict & ~b.strict;
        end
        return r;
    endfunction

endpackage

@@ rtl/cdbm_cell.sv @@
`timescale 1ns / 1ps

module cdbm_cell
    import cdbm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_bound i_d,
    output t_bound o_q
);

    t_bound r_q;

    // one matrix entry, handed on when the chain moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= BOUND_ZERO;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/cdbm_head.sv @@
`timescale 1ns / 1ps

module cdbm_head
    import cdbm_pkg::*;
(
    input  t_head_ctl i_ctl,
    input  t_bound    i_cur,
    output t_bound    o_out
);

    t_bound top_b;
    t_bound bot_b;
    t_bound d;

    // update of the entry leaving the head of the chain
    always_comb begin
        top_b = '{inf: 1'b0, strict: 1'b0,
                  val: signed'({{(VALUE_WIDTH-CONST_W){1'b0}}, i_ctl.maxc})};
        bot_b = '{inf: 1'b0, strict: 1'b1,
                  val: -signed'({{(VALUE_WIDTH-CONST_W){1'b0}}, i_ctl.maxc})};
        d     = bound_add(i_ctl.mik, i_ctl.mkj);
        o_out = i_cur;
        if (i_ctl.in_rng) begin
            unique case (i_ctl.mode)
                M_PASS: begin
                    o_out = i_cur;
                end
                M_DELAY: begin
                    if (i_ctl.col0_row) o_out = BOUND_INF;
                end
                M_RESET: begin
                    if (i_ctl.row_idx) begin
                        o_out = i_ctl.rn_j;
                    end else if (i_ctl.col_idx) begin
                        o_out = i_ctl.cn_i;
                    end
                end
                M_APPLY: begin
                    if (i_ctl.wr_empty) begin
                        if (i_ctl.at00) o_out = BOUND_EMPTY;
                    end else if (i_ctl.at_xy) begin
                        o_out = i_ctl.bnd;
                    end else if (i_ctl.do_close && i_ctl.diag) begin
                        o_out = BOUND_ZERO;
                    end
                end
                M_CLOSE: begin
                    if (bound_lt(d, i_cur)) o_out = d;
                end
                M_NORM: begin
                    if (!i_cur.inf) begin
                        if (bound_lt(top_b, i_cur)) begin
                            o_out = BOUND_INF;
                        end else if (bound_lt(i_cur, bot_b)) begin
                            o_out = bot_b;
                        end
                    end
                end
                default: begin
                    o_out = i_cur;
                end
            endcase
        end
    end

endmodule

@@ rtl/clock_zone_dbm_engine.sv @@
`timescale 1ns / 1ps

// Zone engine on a difference bound matrix held in a ring of 81 cells.
// Command channel: i_cmd is taken at a rising edge with start high and
// busy low. Every command gives exactly one result word on o_result,
// marked by o_done for one cycle; the receiver cannot stall, so the word
// must be taken in that cycle. Configuration (i_cfg_we, i_cfg_idx, i_cfg_data)
// must be written only while busy is low; the block does not enforce it.
// Every pass over the matrix rotates the ring once, one entry a cycle
// through the head unit. Steps from acceptance to o_done:
//   invalid clock or relation: straight to the done state
//   delay: a delay pass; query: a fetch pass; clock reset: a reset pass
//   and a normalize pass; constrain: per bound a fetch pass, a decision,
//   a write pass if the bound is tighter or empties the zone and, after a
//   write into a non-empty zone, closure over n pivots; then normalize.
// n = active clocks + 1, at most 9; closure runs one ring rotation per pivot.
// A new command is accepted in the cycle o_done is shown.
// Reset (i_rst_n low, synchronous) sets every entry to zero non-strict,
// the clock count to 8 and the extrapolation ceiling to 255, at once.
module clock_zone_dbm_engine
    import cdbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DELAY  = 9'b000000010,
        S_RESET  = 9'b000000100,
        S_FETCH  = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_APPLY  = 9'b000100000,
        S_CLOSE  = 9'b001000000,
        S_NORM   = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [ACT_W-1:0]   r_active;
    logic [CONST_W-1:0] r_maxc;
    t_idx               r_pi, r_pj, r_k;
    logic               r_cons;
    logic               r_done;
    t_result            r_out;

    t_idx               r_idx, r_x, r_y;
    logic [CONST_W-1:0] r_c;
    logic [2:0]         r_rel;
    logic               r_query, r_two, r_wr_empty, r_do_close;
    t_bound             r_bnd, r_a, r_b, r_mik;
    t_bound             r_row_buf [DIM];
    t_bound             r_col_buf [DIM];
    t_bound             r_row_nxt [DIM];
    t_bound             r_col_nxt [DIM];
    t_bound             n_row_nxt [DIM];
    t_bound             n_col_nxt [DIM];

    t_bound    w_q [CELLS];
    t_bound    w_head_out;
    t_head_ctl w_ctl;
    logic      w_rot, w_last, w_cap, w_in_rng, w_idx_ok;
    t_cnt      w_n, w_capk;
    t_bound    w_sum;
    logic      w_empty_w, w_tighter;
    t_bound    w_second;
    t_result   w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
            r_maxc   <= MAXC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE: r_active <= i_cfg_data[ACT_W-1:0];
                CFG_MAXC:   r_maxc   <= i_cfg_data[CONST_W-1:0];
                default:    r_active <= r_active;
            endcase
        end
    end

    // matrix size in use and position of the head entry
    assign w_n = (32'(r_active) > MAX_CLOCKS) ? t_cnt'(DIM) : (t_cnt'(r_active) + 1'b1);
    assign w_idx_ok = (i_cmd.clock_index != '0) && (32'(i_cmd.clock_index) < 32'(w_n));
    assign w_rot = (r_state == S_DELAY) || (r_state == S_RESET) || (r_state == S_FETCH) ||
                   (r_state == S_APPLY) || (r_state == S_CLOSE) || (r_state == S_NORM);
    assign w_last = (r_pi == t_idx'(DIM - 1)) && (r_pj == t_idx'(DIM - 1));
    assign w_in_rng = (t_cnt'(r_pi) < w_n) && (t_cnt'(r_pj) < w_n);
    assign w_cap = (r_state == S_RESET) || (r_state == S_APPLY) || (r_state == S_CLOSE);
    assign w_capk = (r_state == S_CLOSE) ? (t_cnt'(r_k) + 1'b1) : '0;

    // chain of cells, head at cell zero
    for (genvar p = 0; p < CELLS; p++) begin : g_cell
        if (p == CELLS - 1) begin : g_tail
            cdbm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_rot),
                .i_d     (w_head_out),
                .o_q     (w_q[p])
            );
        end else begin : g_mid
            cdbm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_rot),
                .i_d     (w_q[p+1]),
                .o_q     (w_q[p])
            );
        end
    end

    // head control word
    always_comb begin
        unique case (r_state)
            S_DELAY: w_ctl.mode = M_DELAY;
            S_RESET: w_ctl.mode = M_RESET;
            S_APPLY: w_ctl.mode = M_APPLY;
            S_CLOSE: w_ctl.mode = M_CLOSE;
            S_NORM:  w_ctl.mode = M_NORM;
            default: w_ctl.mode = M_PASS;
        endcase
        w_ctl.in_rng   = w_in_rng;
        w_ctl.col0_row = (r_pj == '0) && (r_pi != '0);
        w_ctl.row_idx  = (r_pi == r_idx);
        w_ctl.col_idx  = (r_pj == r_idx);
        w_ctl.at_xy    = (r_pi == r_x) && (r_pj == r_y);
        w_ctl.at00     = (r_pi == '0) && (r_pj == '0);
        w_ctl.diag     = (r_pi == r_pj);
        w_ctl.wr_empty = r_wr_empty;
        w_ctl.do_close = r_do_close;
        w_ctl.bnd      = r_bnd;
        w_ctl.rn_j     = r_row_nxt[r_pj];
        w_ctl.cn_i     = r_col_nxt[r_pi];
        w_ctl.mik      = (r_pj <= r_k) ? r_col_buf[r_pi] : r_mik;
        w_ctl.mkj      = r_row_buf[r_pj];
        w_ctl.maxc     = r_maxc;
    end

    cdbm_head u_head (
        .i_ctl (w_ctl),
        .i_cur (w_q[0]),
        .o_out (w_head_out)
    );

    // row and column capture for the next pivot or the clock reset
    always_comb begin
        for (int e = 0; e < DIM; e++) begin
            n_row_nxt[e] = r_row_nxt[e];
            n_col_nxt[e] = r_col_nxt[e];
        end
        if (w_cap && (t_cnt'(r_pi) == w_capk)) n_row_nxt[r_pj] = w_head_out;
        if (w_cap && (t_cnt'(r_pj) == w_capk)) n_col_nxt[r_pi] = w_head_out;
    end

    // bound decision
    assign w_sum     = bound_add(r_a, r_bnd);
    assign w_empty_w = bound_lt(w_sum, BOUND_ZERO);
    assign w_tighter = bound_lt(r_bnd, r_b);
    assign w_second  = '{inf: 1'b0, strict: (r_rel == REL_GREATER),
                         val: -signed'({{(VALUE_WIDTH-CONST_W){1'b0}}, r_c})};

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_cmd.opcode)
                        OP_DELAY:     n_state = S_DELAY;
                        OP_RESET:     n_state = w_idx_ok ? S_RESET : S_DONE;
                        OP_CONSTRAIN: n_state = (w_idx_ok && (i_cmd.relation <= REL_GREATER))
                                                ? S_FETCH : S_DONE;
                        OP_QUERY:     n_state = w_idx_ok ? S_FETCH : S_DONE;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_DELAY: if (w_last) n_state = S_DONE;
            S_RESET: if (w_last) n_state = S_NORM;
            S_FETCH: if (w_last) n_state = r_query ? S_DONE : S_DECIDE;
            S_DECIDE: begin
                if (w_empty_w || w_tighter) begin
                    n_state = S_APPLY;
                end else begin
                    n_state = r_two ? S_FETCH : S_NORM;
                end
            end
            S_APPLY: begin
                if (w_last) begin
                    if (r_do_close) begin
                        n_state = S_CLOSE;
                    end else begin
                        n_state = r_two ? S_FETCH : S_NORM;
                    end
                end
            end
            S_CLOSE: begin
                if (w_last && !((t_cnt'(r_k) + 1'b1) < w_n)) begin
                    n_state = r_two ? S_FETCH : S_NORM;
                end
            end
            S_NORM: if (w_last) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pi    <= '0;
            r_pj    <= '0;
            r_k     <= '0;
            r_cons  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            if (w_rot) begin
                if (r_pj == t_idx'(DIM - 1)) begin
                    r_pj <= '0;
                    r_pi <= w_last ? '0 : (r_pi + 1'b1);
                end else begin
                    r_pj <= r_pj + 1'b1;
                end
                if (w_ctl.at00) begin
                    r_cons <= (w_head_out == BOUND_ZERO);
                end
            end
            if ((r_state == S_APPLY) && w_last) begin
                r_k <= '0;
            end else if ((r_state == S_CLOSE) && w_last) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // command, bound and buffer registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_query <= (i_cmd.opcode == OP_QUERY) && w_idx_ok;
            r_idx   <= t_idx'(i_cmd.clock_index);
            r_c     <= i_cmd.bound_constant;
            r_rel   <= i_cmd.relation;
            r_two   <= (i_cmd.opcode == OP_CONSTRAIN) && (i_cmd.relation == REL_EQUAL);
            if ((i_cmd.opcode == OP_QUERY) || (i_cmd.relation <= REL_EQUAL)) begin
                r_x   <= t_idx'(i_cmd.clock_index);
                r_y   <= '0;
                r_bnd <= '{inf: 1'b0, strict: (i_cmd.relation == REL_LESS),
                           val: signed'({{(VALUE_WIDTH-CONST_W){1'b0}},
                                         i_cmd.bound_constant})};
            end else begin
                r_x   <= '0;
                r_y   <= t_idx'(i_cmd.clock_index);
                r_bnd <= '{inf: 1'b0, strict: (i_cmd.relation == REL_GREATER),
                           val: -signed'({{(VALUE_WIDTH-CONST_W){1'b0}},
                                          i_cmd.bound_constant})};
            end
        end
        // switch to the lower bound of an equality
        if ((n_state == S_FETCH) && (r_state != S_IDLE) && (r_state != S_FETCH)) begin
            r_x   <= '0;
            r_y   <= r_idx;
            r_bnd <= w_second;
            r_two <= 1'b0;
        end
        if (r_state == S_FETCH) begin
            if ((r_pi == r_y) && (r_pj == r_x)) r_a <= w_q[0];
            if ((r_pi == r_x) && (r_pj == r_y)) r_b <= w_q[0];
        end
        if (r_state == S_DECIDE) begin
            r_wr_empty <= w_empty_w;
            r_do_close <= !w_empty_w && r_cons;
        end
        if (w_rot) begin
            for (int e = 0; e < DIM; e++) begin
                r_row_nxt[e] <= n_row_nxt[e];
                r_col_nxt[e] <= n_col_nxt[e];
            end
            if (w_last && ((r_state == S_APPLY) || (r_state == S_CLOSE))) begin
                for (int e = 0; e < DIM; e++) begin
                    r_row_buf[e] <= n_row_nxt[e];
                    r_col_buf[e] <= n_col_nxt[e];
                end
            end else if ((r_state == S_CLOSE) && (r_pi == r_k)) begin
                r_row_buf[r_pj] <= w_head_out;
            end
            if ((r_state == S_CLOSE) && (r_pj == r_k)) begin
                r_mik <= w_head_out;
            end
        end
        if (r_state == S_DONE) begin
            r_out <= w_result;
        end
    end

    // result word, interval clamped to the ceiling
    always_comb begin
        logic signed [VALUE_WIDTH:0] mc_ext;
        logic signed [VALUE_WIDTH:0] lneg;
        logic signed [VALUE_WIDTH:0] uval;
        mc_ext = signed'({{(VALUE_WIDTH+1-CONST_W){1'b0}}, r_maxc});
        lneg   = r_a.val[VALUE_WIDTH-1] ? -signed'({r_a.val[VALUE_WIDTH-1], r_a.val}) : '0;
        uval   = signed'({r_b.val[VALUE_WIDTH-1], r_b.val});
        w_result            = '0;
        w_result.zone_empty = !r_cons;
        if (r_query) begin
            if (!r_cons) begin
                w_result.lower_open = 1'b1;
                w_result.upper_open = 1'b1;
            end else begin
                if (r_a.inf) begin
                    w_result.lower_end  = '0;
                    w_result.lower_open = 1'b0;
                end else if (lneg > mc_ext) begin
                    w_result.lower_end  = r_maxc;
                    w_result.lower_open = 1'b0;
                end else begin
                    w_result.lower_end  = lneg[CONST_W-1:0];
                    w_result.lower_open = r_a.strict;
                end
                if (r_b.inf || (uval > mc_ext)) begin
                    w_result.upper_end  = r_maxc;
                    w_result.upper_open = 1'b0;
                end else if (r_b.val[VALUE_WIDTH-1]) begin
                    w_result.upper_end  = '0;
                    w_result.upper_open = r_b.strict;
                end else begin
                    w_result.upper_end  = r_b.val[CONST_W-1:0];
                    w_result.upper_open = r_b.strict;
                end
            end
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

`ifndef SYNTH
    // o_done drops again after every result word
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // an accepted command makes the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n) (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // ring position stays inside the matrix
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pi <= t_idx'(DIM - 1)) && (r_pj <= t_idx'(DIM - 1)))
        else $error("ring position out of range");

    // an idle ring rests with entry zero at the head
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_pi == '0) && (r_pj == '0)))
        else $error("ring not aligned while idle");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import cdbm_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_cmd                  i_cmd;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    clock_zone_dbm_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // zone model kept by the bench
    typedef struct {
        bit inf;
        bit strict;
        int val;
    } zbound_t;

    zbound_t     zone [DIM][DIM];
    int unsigned clocks_in_use;
    int unsigned ceiling;

    t_result     expected_words [$];
    int          fails;

    // typed-in expectation travelling with the word being offered
    logic        fixed_valid;
    t_result     fixed_word;

    function automatic zbound_t zb(int v, bit s);
        zbound_t b;
        b.inf    = 1'b0;
        b.strict = s;
        b.val    = (v < -65536) ? -65536 : ((v > 65535) ? 65535 : v);
        return b;
    endfunction

    function automatic zbound_t zb_inf();
        zbound_t b;
        b.inf    = 1'b1;
        b.strict = 1'b0;
        b.val    = 0;
        return b;
    endfunction

    function automatic zbound_t zb_sum(zbound_t a, zbound_t b);
        if (a.inf || b.inf) return zb_inf();
        return zb(a.val + b.val, a.strict || b.strict);
    endfunction

    function automatic bit zb_less(zbound_t a, zbound_t b);
        if (a.inf) return 1'b0;
        if (b.inf) return 1'b1;
        if (a.val != b.val) return a.val < b.val;
        return a.strict && !b.strict;
    endfunction

    function automatic bit zone_ok();
        return !zone[0][0].inf && !zone[0][0].strict && zone[0][0].val == 0;
    endfunction

    // floyd-warshall tightening, skipped once the zone is empty
    function automatic void tighten(int n);
        zbound_t d;
        if (!zone_ok()) return;
        for (int i = 0; i < n; i++) zone[i][i] = zb(0, 1'b0);
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    d = zb_sum(zone[i][k], zone[k][j]);
                    if (zb_less(d, zone[i][j])) zone[i][j] = d;
                end
    endfunction

    // extrapolate against the ceiling
    function automatic void extrapolate(int n);
        zbound_t top;
        zbound_t bot;
        top = zb(int'(ceiling), 1'b0);
        bot = zb(-int'(ceiling), 1'b1);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                if (zone[i][j].inf) continue;
                if (zb_less(top, zone[i][j])) zone[i][j] = zb_inf();
                else if (zb_less(zone[i][j], bot)) zone[i][j] = bot;
            end
    endfunction

    function automatic void add_bound(int n, int x, int y, zbound_t b);
        if (zb_less(zb_sum(zone[y][x], b), zb(0, 1'b0))) begin
            zone[0][0] = zb(-1, 1'b1);
            return;
        end
        if (zb_less(b, zone[x][y])) begin
            zone[x][y] = b;
            tighten(n);
        end
    endfunction

    // apply one command word to the zone and give the result word
    function automatic t_result zone_step(t_cmd c);
        t_result r;
        int      n;
        int      ci;
        int      k;
        int      l;
        int      rel;
        bit      ok;
        zbound_t lb;
        zbound_t ub;
        r   = '0;
        n   = ((clocks_in_use > MAX_CLOCKS) ? MAX_CLOCKS : clocks_in_use) + 1;
        ci  = c.clock_index;
        rel = c.relation;
        k   = c.bound_constant;
        ok  = ci >= 1 && ci < n;
        if (c.opcode == OP_DELAY) begin
            for (int i = 1; i < n; i++) zone[i][0] = zb_inf();
        end else if (c.opcode == OP_RESET && ok) begin
            for (int i = 0; i < n; i++) begin
                zone[ci][i] = zb_sum(zb(0, 1'b0), zone[0][i]);
                zone[i][ci] = zb_sum(zone[i][0], zb(0, 1'b0));
            end
            extrapolate(n);
        end else if (c.opcode == OP_CONSTRAIN && ok && rel <= REL_GREATER) begin
            if (rel <= REL_EQUAL) add_bound(n, ci, 0, zb(k, rel == REL_LESS));
            if (rel >= REL_EQUAL) add_bound(n, 0, ci, zb(-k, rel == REL_GREATER));
            extrapolate(n);
        end else if (c.opcode == OP_QUERY && ok) begin
            if (!zone_ok()) begin
                r.lower_open = 1'b1;
                r.upper_open = 1'b1;
            end else begin
                lb = zone[0][ci];
                ub = zone[ci][0];
                l  = (lb.val < 0) ? -lb.val : 0;
                r.lower_open = lb.strict;
                if (lb.inf) begin
                    l = 0;
                    r.lower_open = 1'b0;
                end
                if (l > int'(ceiling)) begin
                    l = ceiling;
                    r.lower_open = 1'b0;
                end
                r.lower_end = 15'(l);
                if (ub.inf || ub.val > int'(ceiling)) begin
                    r.upper_end = 15'(ceiling);
                end else begin
                    r.upper_end  = (ub.val < 0) ? '0 : 15'(ub.val);
                    r.upper_open = ub.strict;
                end
            end
        end
        r.zone_empty = !zone_ok();
        return r;
    endfunction

    // look ahead without touching the zone
    function automatic t_result zone_peek(t_cmd c);
        zbound_t keep [DIM][DIM];
        t_result r;
        keep = zone;
        r    = zone_step(c);
        zone = keep;
        return r;
    endfunction

    // accepted words feed the model, finished words are checked
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        if (i_rst_n && o_done) begin
            got = o_result;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                fails++;
            end else begin
                want = expected_words.pop_front();
                if (got.zone_empty !== want.zone_empty) begin
                    $error("zone_empty exp %0d got %0d", want.zone_empty, got.zone_empty);
                    fails++;
                end
                if (got.lower_end !== want.lower_end) begin
                    $error("lower_end exp %0d got %0d", want.lower_end, got.lower_end);
                    fails++;
                end
                if (got.lower_open !== want.lower_open) begin
                    $error("lower_open exp %0d got %0d", want.lower_open, got.lower_open);
                    fails++;
                end
                if (got.upper_end !== want.upper_end) begin
                    $error("upper_end exp %0d got %0d", want.upper_end, got.upper_end);
                    fails++;
                end
                if (got.upper_open !== want.upper_open) begin
                    $error("upper_open exp %0d got %0d", want.upper_open, got.upper_open);
                    fails++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            pred = zone_step(i_cmd);
            expected_words = {expected_words, (fixed_valid ? fixed_word : pred)};
        end
    end

    // offer one word and hold it until taken; start stays high afterwards
    task automatic send_word(t_cmd c, logic fixed, t_result fw);
        bit taken;
        start       <= 1'b1;
        i_cmd       <= c;
        fixed_valid <= fixed;
        fixed_word  <= fw;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // registers change only when the engine is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        start <= 1'b0;
        @(negedge i_clk);
        while (expected_words.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        if (idx == CFG_ACTIVE) clocks_in_use = data & 4'hF;
        else ceiling = data & 15'h7FFF;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cmd mk_cmd(logic [1:0] op, int ci, int rel, int k);
        t_cmd c;
        c.opcode         = op;
        c.clock_index    = 4'(ci);
        c.relation       = 3'(rel);
        c.bound_constant = 15'(k);
        return c;
    endfunction

    // random word, mostly keeping the zone non-empty
    function automatic t_cmd pick_word();
        t_cmd    c;
        t_result iv;
        int      n;
        int      k;
        n = ((clocks_in_use > MAX_CLOCKS) ? MAX_CLOCKS : clocks_in_use);
        for (int tries = 0; tries < 8; tries++) begin
            c = mk_cmd(OP_QUERY, (n == 0) ? 1 : $urandom_range(n, 1),
                       $urandom_range(REL_GREATER, 0), 0);
            case ($urandom_range(99, 0)) inside
                [0:11]:  c.opcode = OP_DELAY;
                [12:24]: c.opcode = OP_RESET;
                [25:69]: c.opcode = OP_CONSTRAIN;
                default: c.opcode = OP_QUERY;
            endcase
            if ($urandom_range(9, 0) == 0) begin
                c.clock_index = 4'($urandom_range(15, 0));
                c.relation    = 3'($urandom_range(7, 0));
            end
            if (c.opcode == OP_CONSTRAIN) begin
                iv = zone_peek(mk_cmd(OP_QUERY, c.clock_index, 0, 0));
                case ($urandom_range(3, 0))
                    0: k = $urandom_range(32767, 0);
                    1: k = $urandom_range(40, 0);
                    2: k = int'(iv.lower_end) + $urandom_range(6, 0);
                    default: k = int'(iv.upper_end) - $urandom_range(6, 0);
                endcase
                c.bound_constant = (k < 0) ? '0 : 15'(k);
            end
            if (!zone_peek(c).zone_empty) return c;
        end
        return mk_cmd(OP_QUERY, 1, 0, 0);
    endfunction

    typedef struct {
        t_cmd    cmd;
        logic    fixed;
        t_result word;
    } stim_row_t;

    localparam t_result W_ZERO  = '0;

    stim_row_t directed [] = '{
        '{'{OP_QUERY,     4'd1, 3'd0, 15'd0},     1'b1, W_ZERO},
        '{'{OP_QUERY,     4'd8, 3'd0, 15'd0},     1'b1, W_ZERO},
        '{'{OP_DELAY,     4'd0, 3'd0, 15'd0},     1'b1, W_ZERO},
        '{'{OP_QUERY,     4'd1, 3'd0, 15'd0},     1'b1,
          '{zone_empty: 1'b0, lower_end: 15'd0, lower_open: 1'b0,
            upper_end: 15'd255, upper_open: 1'b0}},
        '{'{OP_CONSTRAIN, 4'd1, 3'd1, 15'h7FFF},  1'b1, W_ZERO},
        '{'{OP_CONSTRAIN, 4'd1, 3'd0, 15'd100},   1'b1, W_ZERO},
        '{'{OP_QUERY,     4'd1, 3'd0, 15'd0},     1'b1,
          '{zone_empty: 1'b0, lower_end: 15'd0, lower_open: 1'b0,
            upper_end: 15'd100, upper_open: 1'b1}},
        '{'{OP_CONSTRAIN, 4'd2, 3'd4, 15'd5},     1'b0, W_ZERO},
        '{'{OP_CONSTRAIN, 4'd3, 3'd3, 15'd7},     1'b0, W_ZERO},
        '{'{OP_CONSTRAIN, 4'd4, 3'd2, 15'd50},    1'b0, W_ZERO},
        '{'{OP_QUERY,     4'd2, 3'd0, 15'd0},     1'b0, W_ZERO},
        '{'{OP_QUERY,     4'd3, 3'd0, 15'd0},     1'b0, W_ZERO},
        '{'{OP_RESET,     4'd2, 3'd0, 15'd0},     1'b0, W_ZERO},
        '{'{OP_QUERY,     4'd2, 3'd0, 15'd0},     1'b0, W_ZERO},
        '{'{OP_CONSTRAIN, 4'd1, 3'd5, 15'd3},     1'b1, W_ZERO},
        '{'{OP_CONSTRAIN, 4'd1, 3'd7, 15'h7FFF},  1'b1, W_ZERO},
        '{'{OP_CONSTRAIN, 4'd0, 3'd1, 15'd1},     1'b1, W_ZERO},
        '{'{OP_RESET,     4'd9, 3'd0, 15'd0},     1'b1, W_ZERO},
        '{'{OP_QUERY,     4'd0, 3'd0, 15'd0},     1'b1, W_ZERO},
        '{'{OP_QUERY,     4'd15, 3'd0, 15'd0},    1'b1, W_ZERO},
        '{'{OP_DELAY,     4'd0, 3'd0, 15'd0},     1'b0, W_ZERO},
        '{'{OP_QUERY,     4'd4, 3'd0, 15'd0},     1'b0, W_ZERO}
    };

    // register settings walked by the random part
    int unsigned phase_active [] = '{8, 1, 15, 0, 3, 5, 8, 2};
    int unsigned phase_ceil   [] = '{255, 0, 32767, 100, 7, 1000, 32767, 40};

    initial begin
        int left;
        fails       = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_ACTIVE;
        i_cfg_data  = '0;
        fixed_valid = 1'b0;
        fixed_word  = '0;
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++) zone[i][j] = zb(0, 1'b0);
        clocks_in_use = ACTIVE_RESET;
        ceiling       = MAXC_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed[r]) begin
            send_word(directed[r].cmd, directed[r].fixed, directed[r].word);
            if ($urandom_range(2, 0) == 0) pause_sender($urandom_range(5, 1));
        end

        // random phases, each under its own register setting
        foreach (phase_active[p]) begin
            write_reg(CFG_ACTIVE, phase_active[p]);
            write_reg(CFG_MAXC, phase_ceil[p]);
            left = 92;
            while (left > 0) begin
                for (int b = $urandom_range(20, 1); b > 0 && left > 0; b--) begin
                    send_word(pick_word(), 1'b0, W_ZERO);
                    left--;
                end
                if ($urandom_range(3, 0) != 0) pause_sender($urandom_range(30, 1));
            end
        end

        // an empty zone stays empty, so this comes last
        send_word(mk_cmd(OP_CONSTRAIN, 1, REL_LESS, 0), 1'b0, W_ZERO);
        send_word(mk_cmd(OP_QUERY, 1, 0, 0), 1'b0, W_ZERO);
        send_word(mk_cmd(OP_DELAY, 0, 0, 0), 1'b0, W_ZERO);
        send_word(mk_cmd(OP_RESET, 1, 0, 0), 1'b0, W_ZERO);
        send_word(mk_cmd(OP_QUERY, 2, 0, 0), 1'b0, W_ZERO);
        start <= 1'b0;

        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (2100) @(negedge i_clk);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400ms;
        $display("status: fail");
        $finish;
    end

endmodule
